// ===== design/uart8n1_pkg.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 package
// Shared constants and the status structs passed between the transceiver
// top level and its receive and transmit engines.
// ----------------------------------------------------------------------------
package uart8n1_pkg;

  // Data bits per frame on the line.
  localparam int DATA_BITS = 8;

  localparam int PERIOD_W = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 4;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RX_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_TX_ENABLE  = 2'd2;

  // Characters that mark the end of a line.
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic              got;
    logic [BYTE_W-1:0] val;
    logic              eol;
  } rx_result_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_status_t;

endpackage

// ===== design/uart8n1_rx.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 receiver engine
// Advances the receive state by one line tick whenever step is high and
// reports a completed byte for that tick.
// ----------------------------------------------------------------------------
module uart8n1_rx (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                line,
  input  logic                                rx_enable,
  input  logic [uart8n1_pkg::PERIOD_W-1:0]    bit_period,
  output uart8n1_pkg::rx_result_t             res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  phase_t                                  phase_r, phase_nxt;
  logic [uart8n1_pkg::PERIOD_W-1:0]        timer_r, timer_nxt;
  logic [uart8n1_pkg::DATA_BITS-1:0]       shift_r, shift_nxt;
  logic [uart8n1_pkg::CNT_W-1:0]           left_r, left_nxt;
  logic                                    expired;
  logic [uart8n1_pkg::CNT_W-1:0]           left_dec;
  logic [uart8n1_pkg::BYTE_W-1:0]          byte_val;

  // A timer holding zero or one runs out in the current tick.
  assign expired  = (timer_r <= uart8n1_pkg::PERIOD_W'(1));
  assign left_dec = left_r - uart8n1_pkg::CNT_W'(1);
  assign byte_val = uart8n1_pkg::BYTE_W'(shift_r);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    res       = '0;
    if (step) begin
      if (!rx_enable) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (!line) begin
              phase_nxt = PH_START;
              timer_nxt = bit_period >> 1;
              shift_nxt = '0;
            end
          end
          PH_START: begin
            if (expired) begin
              phase_nxt = PH_DATA;
              timer_nxt = bit_period;
              left_nxt  = uart8n1_pkg::CNT_W'(uart8n1_pkg::DATA_BITS);
            end else begin
              timer_nxt = timer_r - uart8n1_pkg::PERIOD_W'(1);
            end
          end
          PH_DATA: begin
            if (expired) begin
              shift_nxt = {line, shift_r[uart8n1_pkg::DATA_BITS-1:1]};
              timer_nxt = bit_period;
              left_nxt  = left_dec;
              if (left_dec == '0) begin
                phase_nxt = PH_STOP;
              end
            end else begin
              timer_nxt = timer_r - uart8n1_pkg::PERIOD_W'(1);
            end
          end
          PH_STOP: begin
            if (line) begin
              res.got   = 1'b1;
              res.val   = byte_val;
              res.eol   = (byte_val == uart8n1_pkg::CHAR_LF) ||
                          (byte_val == uart8n1_pkg::CHAR_CR) ||
                          (byte_val == uart8n1_pkg::CHAR_NUL);
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shift_r <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== design/uart8n1_tx.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 transmitter engine
// Advances the transmit state by one line tick whenever step is high and
// reports the line level and busy flag after that tick.
// ----------------------------------------------------------------------------
module uart8n1_tx (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                req,
  input  logic [uart8n1_pkg::BYTE_W-1:0]      sbyte,
  input  logic                                tx_enable,
  input  logic [uart8n1_pkg::PERIOD_W-1:0]    bit_period,
  output uart8n1_pkg::tx_status_t             status
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  phase_t                                  phase_r, phase_nxt;
  logic [uart8n1_pkg::PERIOD_W-1:0]        timer_r, timer_nxt;
  logic [uart8n1_pkg::DATA_BITS-1:0]       shift_r, shift_nxt;
  logic [uart8n1_pkg::CNT_W-1:0]           left_r, left_nxt;
  logic                                    expired;
  logic [uart8n1_pkg::CNT_W-1:0]           left_dec;

  assign expired  = (timer_r <= uart8n1_pkg::PERIOD_W'(1));
  assign left_dec = left_r - uart8n1_pkg::CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    if (step) begin
      if (!tx_enable) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (req) begin
              phase_nxt = PH_START;
              timer_nxt = bit_period;
              shift_nxt = uart8n1_pkg::DATA_BITS'(sbyte);
            end
          end
          PH_START: begin
            if (expired) begin
              phase_nxt = PH_DATA;
              timer_nxt = bit_period;
              left_nxt  = uart8n1_pkg::CNT_W'(uart8n1_pkg::DATA_BITS);
            end else begin
              timer_nxt = timer_r - uart8n1_pkg::PERIOD_W'(1);
            end
          end
          PH_DATA: begin
            if (expired) begin
              shift_nxt = shift_r >> 1;
              timer_nxt = bit_period;
              left_nxt  = left_dec;
              if (left_dec == '0) begin
                phase_nxt = PH_STOP;
              end
            end else begin
              timer_nxt = timer_r - uart8n1_pkg::PERIOD_W'(1);
            end
          end
          PH_STOP: begin
            if (expired) begin
              phase_nxt = PH_IDLE;
            end else begin
              timer_nxt = timer_r - uart8n1_pkg::PERIOD_W'(1);
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Line level and busy flag as they stand after this tick.
  always_comb begin
    unique case (phase_nxt)
      PH_START: status.line = 1'b0;
      PH_DATA:  status.line = shift_nxt[0];
      default:  status.line = 1'b1;
    endcase
    status.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      shift_r <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== design/uart_8n1_transceiver_unit.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 transceiver unit
// Path: an input transfer is captured in the input register, and its result
// is then registered in the result register and offered on the out channel.
// Throughput: one tick per cycle, sustained, as long as out_tready is high.
// Reset: rst_n is synchronous and active low; both engines return to idle,
// registers take their reset values (bit period 104, both sides enabled).
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream, one transfer per line tick.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] rx_line, [1] send_valid, [9:2] send_byte, rest zero
  // Result stream, one transfer per line tick.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] tx_line, [1] tx_busy, [2] byte_valid,
                                  // [10:3] byte_out, [11] line_end, rest zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers. The user must write them only while the unit is idle;
  // the block does not enforce this. A new bit period shows up at the next timer reload.
  logic [uart8n1_pkg::PERIOD_W-1:0] bit_period_r;
  logic                             rx_enable_r;
  logic                             tx_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= uart8n1_pkg::BIT_PERIOD_RESET;
      rx_enable_r  <= 1'b1;
      tx_enable_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        uart8n1_pkg::CFG_BIT_PERIOD: bit_period_r <= cfg_wdata;
        uart8n1_pkg::CFG_RX_ENABLE:  rx_enable_r  <= cfg_wdata[0];
        uart8n1_pkg::CFG_TX_ENABLE:  tx_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Result register. It holds a finished result while the consumer stalls,
  // and the input register below keeps the next tick waiting meanwhile.
  logic        out_v_r;
  logic [15:0] out_data_r;

  // Input register. It accepts a new transfer while the tick it holds is being
  // processed, so a new transfer can land every cycle while the result side does not stall.
  logic                           in_v_r;
  logic                           in_line_r;
  logic                           in_req_r;
  logic [uart8n1_pkg::BYTE_W-1:0] in_byte_r;
  logic                           step;

  // A held tick is processed when the result register can take its result.
  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_line_r <= in_tdata[0];
      in_req_r  <= in_tdata[1];
      in_byte_r <= in_tdata[9:2];
    end
  end

  // The two engines share only the clock, reset, bit period and step strobe.
  uart8n1_pkg::rx_result_t rx_res;
  uart8n1_pkg::tx_status_t tx_stat;

  uart8n1_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .line       (in_line_r),
    .rx_enable  (rx_enable_r),
    .bit_period (bit_period_r),
    .res        (rx_res)
  );

  uart8n1_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .req        (in_req_r),
    .sbyte      (in_byte_r),
    .tx_enable  (tx_enable_r),
    .bit_period (bit_period_r),
    .status     (tx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {4'b0000, rx_res.eol, rx_res.val, rx_res.got,
                     tx_stat.busy, tx_stat.line};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/uart8n1_checker.sv =====
// ----------------------------------------------------------------------------
// UART 8N1 port checker
// Watches the top level's ports for result stream and field consistency.
// ----------------------------------------------------------------------------
module uart8n1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // Without a received byte, byte_out and line_end are zero.
  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[10:3] == 8'h00 && !out_tdata[11])
    else $error("byte fields set without byte_valid");

  // line_end only for newline, carriage return or zero.
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |->
      out_tdata[2] && (out_tdata[10:3] == 8'h0A || out_tdata[10:3] == 8'h0D ||
                       out_tdata[10:3] == 8'h00))
    else $error("line_end on a byte that does not end a line");

  // An idle transmitter holds the line high.
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[0])
    else $error("tx line low while not busy");

endmodule

bind uart_8n1_transceiver_unit uart8n1_checker u_uart8n1_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/uart_8n1_transceiver_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver unit testbench
// Streams line ticks into the unit. Each tick carries the receive pin level
// and an optional send request. A cycle-accurate line model predicts the
// transmit pin, the busy flag and any completed received byte for every
// tick. Both stream sides idle and stall at random, and the configuration
// is changed between traffic phases once every predicted result is back.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_unit_test;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 600000;

  // One line tick as it travels on in_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [5:0]                     spare;
    logic [uart8n1_pkg::BYTE_W-1:0] send_byte;
    logic                           send_valid;
    logic                           rx_line;
  } line_tick_t;

  // One tick result as it travels on out_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [3:0]                     spare;
    logic                           line_end;
    logic [uart8n1_pkg::BYTE_W-1:0] byte_out;
    logic                           byte_valid;
    logic                           tx_busy;
    logic                           tx_line;
  } tick_status_t;

  // Frame phases shared by the receive and transmit engines of the model.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } frame_phase_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = uart8n1_pkg::CFG_BIT_PERIOD;
  logic [15:0] cfg_wdata  = '0;

  uart_8n1_transceiver_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Ticks waiting to be driven, and the statuses predicted for ticks that
  // have already been transferred into the unit.
  line_tick_t   pending_ticks[$];
  tick_status_t predicted_status[$];

  int ticks_made   = 0;
  int mismatches   = 0;
  int cycle_count  = 0;
  int send_gap     = 0;
  int hold_gap     = 0;
  int request_odds = 40;
  bit calm         = 1'b0;

  // Line model: configuration copy and the state of both engines.
  logic [uart8n1_pkg::PERIOD_W-1:0] tick_period;
  logic                             rx_on;
  logic                             tx_on;
  frame_phase_t                     rx_phase;
  logic [uart8n1_pkg::PERIOD_W-1:0] rx_count;
  logic [uart8n1_pkg::BYTE_W-1:0]   rx_bits;
  logic [uart8n1_pkg::CNT_W-1:0]    rx_remaining;
  frame_phase_t                     tx_phase;
  logic [uart8n1_pkg::PERIOD_W-1:0] tx_count;
  logic [uart8n1_pkg::BYTE_W-1:0]   tx_bits;
  logic [uart8n1_pkg::CNT_W-1:0]    tx_remaining;

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------

  function automatic void clear_line_model();
    tick_period  = uart8n1_pkg::BIT_PERIOD_RESET;
    rx_on        = 1'b1;
    tx_on        = 1'b1;
    rx_phase     = PH_IDLE;
    rx_count     = '0;
    rx_bits      = '0;
    rx_remaining = '0;
    tx_phase     = PH_IDLE;
    tx_count     = '0;
    tx_bits      = '0;
    tx_remaining = '0;
  endfunction

  // Advances both engines by one line tick and returns the pin and receive
  // status as seen after the tick. A timer that holds 0 or 1 at the start of
  // a tick expires in that tick; a new period only applies at the next reload.
  function automatic tick_status_t advance_line(input line_tick_t t);
    tick_status_t s;
    s = '0;

    // Receiver. The start bit is never checked again once the line went low,
    // and the byte is only released on the first high tick after the last
    // data sample.
    if (!rx_on) begin
      rx_phase = PH_IDLE;
    end else begin
      case (rx_phase)
        PH_IDLE: begin
          if (!t.rx_line) begin
            rx_phase = PH_START;
            rx_count = tick_period >> 1;
            rx_bits  = '0;
          end
        end
        PH_START: begin
          if (rx_count <= 1) begin
            rx_phase     = PH_DATA;
            rx_count     = tick_period;
            rx_remaining = uart8n1_pkg::CNT_W'(uart8n1_pkg::DATA_BITS);
          end else begin
            rx_count = rx_count - 1'b1;
          end
        end
        PH_DATA: begin
          if (rx_count <= 1) begin
            rx_bits      = {t.rx_line, rx_bits[uart8n1_pkg::BYTE_W-1:1]};
            rx_count     = tick_period;
            rx_remaining = rx_remaining - 1'b1;
            if (rx_remaining == 0) rx_phase = PH_STOP;
          end else begin
            rx_count = rx_count - 1'b1;
          end
        end
        default: begin
          if (t.rx_line) begin
            s.byte_valid = 1'b1;
            s.byte_out   = rx_bits;
            s.line_end   = (rx_bits == uart8n1_pkg::CHAR_LF) ||
                           (rx_bits == uart8n1_pkg::CHAR_CR) ||
                           (rx_bits == uart8n1_pkg::CHAR_NUL);
            rx_phase     = PH_IDLE;
          end
        end
      endcase
    end

    // Transmitter. A request is only taken while idle at the start of the
    // tick; disabling it drops the frame and holds the pin high.
    if (!tx_on) begin
      tx_phase = PH_IDLE;
    end else begin
      case (tx_phase)
        PH_IDLE: begin
          if (t.send_valid) begin
            tx_phase = PH_START;
            tx_count = tick_period;
            tx_bits  = t.send_byte;
          end
        end
        PH_START: begin
          if (tx_count <= 1) begin
            tx_phase     = PH_DATA;
            tx_count     = tick_period;
            tx_remaining = uart8n1_pkg::CNT_W'(uart8n1_pkg::DATA_BITS);
          end else begin
            tx_count = tx_count - 1'b1;
          end
        end
        PH_DATA: begin
          if (tx_count <= 1) begin
            tx_bits      = tx_bits >> 1;
            tx_count     = tick_period;
            tx_remaining = tx_remaining - 1'b1;
            if (tx_remaining == 0) tx_phase = PH_STOP;
          end else begin
            tx_count = tx_count - 1'b1;
          end
        end
        default: begin
          if (tx_count <= 1) begin
            tx_phase = PH_IDLE;
          end else begin
            tx_count = tx_count - 1'b1;
          end
        end
      endcase
    end

    case (tx_phase)
      PH_START: s.tx_line = 1'b0;
      PH_DATA:  s.tx_line = tx_bits[0];
      default:  s.tx_line = 1'b1;
    endcase
    s.tx_busy = (tx_phase != PH_IDLE);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stream handshakes
  // --------------------------------------------------------------------------

  // Most gaps are zero; some are short and a rare one is long. While
  // calm is set neither side idles at all.
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Cycle counter, calm stretches and the overall timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("uart_8n1_transceiver_unit test failed");
      $finish;
    end
  end

  // Input driver: presents the next pending tick whenever the channel is free
  // and no gap is being served, and draws a new gap after each transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_tdata  <= pending_ticks.pop_front();
          in_tvalid <= 1'b1;
          send_gap  <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_gap > 0) begin
        hold_gap   <= hold_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold_gap   <= pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  // Monitor: mirrors register writes into the model, predicts a status for
  // every input transfer and checks every result transfer against the
  // oldest prediction. The result side is handled first so that a spurious
  // result can never consume a prediction made at the same edge.
  always @(posedge clk) begin
    tick_status_t want;
    tick_status_t seen;
    if (!rst_n) begin
      clear_line_model();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (predicted_status.size() == 0) begin
          $error("result transfer 0x%0h arrived with no tick outstanding", out_tdata);
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          check_field("tx_line",    want.tx_line,    seen.tx_line);
          check_field("tx_busy",    want.tx_busy,    seen.tx_busy);
          check_field("byte_valid", want.byte_valid, seen.byte_valid);
          check_field("byte_out",   want.byte_out,   seen.byte_out);
          check_field("line_end",   want.line_end,   seen.line_end);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          uart8n1_pkg::CFG_BIT_PERIOD: tick_period = cfg_wdata;
          uart8n1_pkg::CFG_RX_ENABLE:  rx_on       = cfg_wdata[0];
          uart8n1_pkg::CFG_TX_ENABLE:  tx_on       = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predicted_status.push_back(advance_line(in_tdata));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_item(input logic rx, input logic req, input logic [7:0] b);
    line_tick_t t;
    t            = '0;
    t.rx_line    = rx;
    t.send_valid = req;
    t.send_byte  = b;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  // A tick with the given receive level and a random send request.
  task automatic push_tick(input logic rx);
    push_item(rx, $urandom_range(0, request_odds - 1) == 0, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_idle(input int n);
    repeat (n) push_tick(1'b1);
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_tick(1'($urandom_range(0, 1)));
  endtask

  // A well-formed frame on the receive pin. late_ticks holds the line low
  // past the stop bit position so that the receiver has to wait for high.
  task automatic push_frame(input int bp, input logic [7:0] b, input int stop_ticks,
                            input int late_ticks);
    repeat (bp) push_tick(1'b0);
    for (int i = 0; i < uart8n1_pkg::DATA_BITS; i++) repeat (bp) push_tick(b[i]);
    repeat (late_ticks) push_tick(1'b0);
    repeat (stop_ticks) push_tick(1'b1);
  endtask

  // A frame cut short after a few bits, followed by an idle high line.
  task automatic push_broken(input int bp);
    int bits;
    bits = $urandom_range(0, 6);
    repeat ($urandom_range(1, bp)) push_tick(1'b0);
    repeat (bits) repeat (bp) push_tick(1'($urandom_range(0, 1)));
    push_idle(2 * bp);
  endtask

  function automatic logic [7:0] line_end_char();
    case ($urandom_range(0, 2))
      0:       return uart8n1_pkg::CHAR_LF;
      1:       return uart8n1_pkg::CHAR_CR;
      default: return uart8n1_pkg::CHAR_NUL;
    endcase
  endfunction

  // Waits until every tick has been transferred and every status checked.
  task automatic settle();
    while (pending_ticks.size() != 0 || in_tvalid || predicted_status.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers only change while the unit has nothing in flight.
  task automatic set_config(input logic [15:0] bp, input logic rx_en, input logic tx_en);
    settle();
    write_reg(uart8n1_pkg::CFG_BIT_PERIOD, bp);
    write_reg(uart8n1_pkg::CFG_RX_ENABLE, {15'd0, rx_en});
    write_reg(uart8n1_pkg::CFG_TX_ENABLE, {15'd0, tx_en});
    @(negedge clk);
  endtask

  // Mostly well-formed frames with random content and gaps, some with a
  // sender period one tick off, some with a late stop bit, plus line noise
  // and truncated frames.
  task automatic random_traffic(input int bp, input int ticks);
    int stop_at;
    int kind;
    int frame_bp;
    logic [7:0] b;
    stop_at = ticks_made + ticks;
    while (ticks_made < stop_at) begin
      kind     = $urandom_range(0, 99);
      b        = ($urandom_range(0, 4) == 0) ? line_end_char() : 8'($urandom_range(0, 255));
      frame_bp = bp;
      if ($urandom_range(0, 4) == 0) frame_bp = bp + $urandom_range(0, 2) - 1;
      push_idle($urandom_range(0, bp));
      if (kind < 75) begin
        push_frame(frame_bp, b, $urandom_range(1, bp),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2 * bp) : 0);
      end else if (kind < 88) begin
        push_noise($urandom_range(1, bp));
      end else begin
        push_broken(bp);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    int bp;
    logic rx_en;
    logic tx_en;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: a frame goes out with all ones, further requests
    // arrive while the transmitter is busy and must be ignored. A single low
    // tick starts the receiver even though the line goes straight back high.
    push_item(1'b1, 1'b1, 8'hFF);
    repeat (20) push_item(1'b1, 1'b1, 8'($urandom_range(0, 255)));
    push_item(1'b0, 1'b0, 8'h00);
    repeat (40) push_item(1'b1, 1'b0, 8'h00);

    // Both engines disabled mid-frame: frames in progress are dropped, the
    // transmit pin stays high and requests go nowhere.
    set_config(16'd8, 1'b0, 1'b0);
    repeat (6) push_item(1'b0, 1'b1, 8'h81);
    push_noise(10);

    // Shortest period: line-end characters, a one-tick stop bit followed at
    // once by the next start bit, a late stop bit and a truncated frame.
    request_odds = 25;
    set_config(16'd8, 1'b1, 1'b1);
    push_item(1'b1, 1'b1, 8'h00);
    push_frame(8, uart8n1_pkg::CHAR_NUL, 1, 0);
    push_frame(8, uart8n1_pkg::CHAR_LF, 4, 0);
    push_frame(8, uart8n1_pkg::CHAR_CR, 8, 0);
    push_frame(8, 8'hFF, 2, 12);
    push_broken(8);

    // Odd period, where the half-period start delay rounds down.
    set_config(16'd9, 1'b1, 1'b1);
    push_frame(9, 8'h5A, 3, 0);

    // Longest period: both engines start and then get dropped by disabling
    // each side in turn.
    set_config(16'hFFFF, 1'b1, 1'b1);
    push_item(1'b0, 1'b1, 8'hC3);
    repeat (120) push_tick(1'b0);
    set_config(16'hFFFF, 1'b0, 1'b1);
    push_noise(5);
    set_config(16'hFFFF, 1'b1, 1'b0);
    push_noise(5);
    set_config(16'd8, 1'b0, 1'b0);
    push_noise(4);

    // Random phases. Each boundary usually falls mid-frame, so a new period
    // lands on frames already in progress.
    while (ticks_made < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       bp = 8;
        1:       bp = 9;
        2, 3:    bp = $urandom_range(8, 12);
        4:       bp = $urandom_range(13, 24);
        default: bp = 16;
      endcase
      rx_en        = ($urandom_range(0, 7) != 0);
      tx_en        = ($urandom_range(0, 7) != 0);
      request_odds = $urandom_range(5, 60);
      set_config(16'(bp), rx_en, tx_en);
      random_traffic(bp, $urandom_range(120, 300));
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("uart_8n1_transceiver_unit test passed");
    end else begin
      $display("uart_8n1_transceiver_unit test failed");
    end
    $finish;
  end

endmodule
